// ===== rtl/cpi_pkg.sv =====
// ----------------------------------------------------------------------------
// cpi_pkg: shared types and constants of the color palette indexer
// Field widths, register codes and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cpi_pkg;

   // Width of one color channel and of the index and count fields.
   localparam int CHAN_W = 8;

   // Channels that the input transaction carries.
   localparam int PORT_CHANNELS = 4;

   // Index returned for a color that could not be placed in the table.
   localparam logic [CHAN_W-1:0] NOT_INDEXED = 8'd255;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CC_W       = 3;
   localparam logic [CC_W-1:0] CC_RESET = 3'd3;

   // Register index, taken from address bit 2 (word address).
   localparam logic REG_CHANNEL_COUNT = 1'b0;

   typedef logic [CHAN_W-1:0] byte_type;
   typedef logic [CC_W-1:0]   chan_count_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // capture a new pixel and restart the scan
      logic scan;     // walk the table one entry per cycle
      logic finish;   // insert if needed and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;      // the compare stage found the key
      logic miss;     // every stored entry has been compared without a match
      logic out_free; // the result register can take a new result
   } status_type;

endpackage

// ===== rtl/cpi_req_if.sv =====
// ----------------------------------------------------------------------------
// cpi_req_if: pixel input channel
// Valid/ready channel carrying one pixel and its start-of-image flag.
// ----------------------------------------------------------------------------
interface cpi_req_if;
   logic               valid;
   logic               ready;
   logic               start_of_image;
   cpi_pkg::byte_type  chan0;
   cpi_pkg::byte_type  chan1;
   cpi_pkg::byte_type  chan2;
   cpi_pkg::byte_type  chan3;

   modport source (
      output valid, start_of_image, chan0, chan1, chan2, chan3,
      input  ready
   );

   modport sink (
      input  valid, start_of_image, chan0, chan1, chan2, chan3,
      output ready
   );
endinterface

// ===== rtl/cpi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cpi_rsp_if: palette index result channel
// Valid/ready channel carrying the index result of one pixel.
// ----------------------------------------------------------------------------
interface cpi_rsp_if;
   logic               valid;
   logic               ready;
   cpi_pkg::byte_type  color_index;
   logic               is_new_color;
   cpi_pkg::byte_type  distinct_count;
   logic               table_full;

   modport source (
      output valid, color_index, is_new_color, distinct_count, table_full,
      input  ready
   );

   modport sink (
      input  valid, color_index, is_new_color, distinct_count, table_full,
      output ready
   );
endinterface

// ===== rtl/color_palette_indexer.sv =====
// ----------------------------------------------------------------------------
// color_palette_indexer: first-seen color palette indexer
// Assigns each pixel the index of its color in a table of distinct colors
// kept in first-seen order, with an APB-style register for the channel count.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Transaction content
//   req_bus   in         valid/ready           start_of_image, chan0..chan3
//   rsp_bus   out        valid/ready           color_index, is_new_color,
//                                              distinct_count, table_full
//   csr       in         psel/penable/pready   channel_count at byte address 0
//
// A pixel that matches a table entry ends its scan at that entry; a new color is
// inserted, if there is room, once every stored entry has been compared.
// The scan reads one stored color per cycle from the table's single read port,
// and the next pixel is accepted only after the result is loaded and the
// controller is back in its idle state. Reset empties the table and sets
// the channel count to 3. A result not yet taken holds the next pixel after its scan.
//
module color_palette_indexer #(
   parameter int TABLE_DEPTH  = 255,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   cpi_req_if.sink                             req_bus,
   cpi_rsp_if.source                           rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cpi_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cpi_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cpi_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   cpi_pkg::cmd_type        cmd;
   cpi_pkg::status_type     status;
   cpi_pkg::chan_count_type chan_count_ff;
   logic                    csr_write;
   logic                    csr_hit;

   // The register file is a single word; address bit 2 selects the word, so
   // writes to any other word are ignored and read back as zero.
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == cpi_pkg::REG_CHANNEL_COUNT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= cpi_pkg::CC_RESET;
      end else if (csr_write) begin
         chan_count_ff <= pwdata[cpi_pkg::CC_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata[cpi_pkg::CC_W-1:0] = chan_count_ff;
      end
   end

   // The controller decides when to accept, scan and finish; the datapath
   // holds the table, the scan pipeline and the output register.
   cpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpi_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .chan_count     (chan_count_ff),
      .start_of_image (req_bus.start_of_image),
      .chan0          (req_bus.chan0),
      .chan1          (req_bus.chan1),
      .chan2          (req_bus.chan2),
      .chan3          (req_bus.chan3),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .color_index    (rsp_bus.color_index),
      .is_new_color   (rsp_bus.is_new_color),
      .distinct_count (rsp_bus.distinct_count),
      .table_full     (rsp_bus.table_full)
   );

endmodule

// ===== rtl/cpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpi_ctrl: sequencing controller of the palette indexer
// Takes one pixel at a time, runs the table scan and hands the result to
// the output register once it is free.
// ----------------------------------------------------------------------------
module cpi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpi_pkg::status_type status,
   output cpi_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.miss) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/cpi_datapath.sv =====
// ----------------------------------------------------------------------------
// cpi_datapath: color table, scan pipeline and result register
// Holds the color table memory, walks it with a read stage and a compare
// stage, inserts new colors and keeps the registered result.
// ----------------------------------------------------------------------------
module cpi_datapath #(
   parameter int TABLE_DEPTH  = 255,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cpi_pkg::cmd_type        cmd,
   output cpi_pkg::status_type     status,
   input  cpi_pkg::chan_count_type chan_count,
   input  logic                    start_of_image,
   input  cpi_pkg::byte_type       chan0,
   input  cpi_pkg::byte_type       chan1,
   input  cpi_pkg::byte_type       chan2,
   input  cpi_pkg::byte_type       chan3,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cpi_pkg::byte_type       color_index,
   output logic                    is_new_color,
   output cpi_pkg::byte_type       distinct_count,
   output logic                    table_full
);

   localparam int KEY_W = cpi_pkg::CHAN_W * MAX_CHANNELS;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   logic [KEY_W-1:0] table_mem [TABLE_DEPTH];

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] scan_idx_ff;
   logic             rd_valid_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic             found_ff;
   logic [CNT_W-1:0] found_idx_ff;
   logic             rsp_valid_ff;
   cpi_pkg::byte_type color_index_ff;
   logic             is_new_ff;
   cpi_pkg::byte_type distinct_ff;
   logic             full_ff;

   logic [cpi_pkg::PORT_CHANNELS-1:0][cpi_pkg::CHAN_W-1:0] chans;
   cpi_pkg::chan_count_type eff_channels;
   logic             issue;
   logic             insert;

   // Key of the incoming pixel: channels past the effective count are zero.
   always_comb begin
      chans = {chan3, chan2, chan1, chan0};
      if (chan_count == '0) begin
         eff_channels = cpi_pkg::chan_count_type'(1);
      end else if (chan_count > cpi_pkg::chan_count_type'(MAX_CHANNELS)) begin
         eff_channels = cpi_pkg::chan_count_type'(MAX_CHANNELS);
      end else begin
         eff_channels = chan_count;
      end
      key_in = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (cpi_pkg::chan_count_type'(c) < eff_channels) begin
            key_in[c*cpi_pkg::CHAN_W +: cpi_pkg::CHAN_W] = chans[c];
         end
      end
   end

   assign issue         = cmd.scan && (scan_idx_ff < count_ff) && !status.hit;
   assign status.hit    = rd_valid_ff && (rd_data_ff == key_ff);
   assign status.miss   = !rd_valid_ff && (scan_idx_ff == count_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign insert        = cmd.finish && !found_ff && (count_ff < DEPTH_CNT);

   always_comb begin
      count_in = count_ff;
      if (cmd.accept && start_of_image) begin
         count_in = '0;
      end else if (insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Table memory: one write port for inserts, one registered read port.
   always_ff @(posedge clock) begin
      if (insert) begin
         table_mem[count_ff[IDX_W-1:0]] <= key_ff;
      end
      if (issue) begin
         rd_data_ff <= table_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= key_in;
      end
      if (issue) begin
         rd_idx_ff <= scan_idx_ff;
      end
      if (cmd.scan && (status.hit || status.miss)) begin
         found_ff     <= status.hit;
         found_idx_ff <= rd_idx_ff;
      end
      if (cmd.finish) begin
         is_new_ff   <= insert;
         distinct_ff <= cpi_pkg::byte_type'(count_in);
         full_ff     <= (count_in >= DEPTH_CNT);
         if (found_ff) begin
            color_index_ff <= cpi_pkg::byte_type'(found_idx_ff);
         end else if (insert) begin
            color_index_ff <= cpi_pkg::byte_type'(count_ff);
         end else begin
            color_index_ff <= cpi_pkg::NOT_INDEXED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.accept) begin
            scan_idx_ff <= '0;
            rd_valid_ff <= 1'b0;
         end else begin
            rd_valid_ff <= issue;
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign color_index    = color_index_ff;
   assign is_new_color   = is_new_ff;
   assign distinct_count = distinct_ff;
   assign table_full     = full_ff;

endmodule

// ===== rtl/cpi_checker.sv =====
// ----------------------------------------------------------------------------
// cpi_checker: port-level checks of the palette indexer
// Watches the channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module cpi_checker #(
   parameter int TABLE_DEPTH = 255
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cpi_pkg::byte_type color_index,
   input logic              is_new_color,
   input cpi_pkg::byte_type distinct_count,
   input logic              table_full
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // A new color takes the slot after the stored colors: its index is the distinct count minus one.
   a_new_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_new_color |-> color_index == distinct_count - 8'd1)
      else $error("new color index does not match the distinct count");

   // The full flag follows the distinct count.
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> table_full == (distinct_count == cpi_pkg::byte_type'(TABLE_DEPTH)))
      else $error("table_full disagrees with distinct_count");

   // Only one pixel is in work at a time.
   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second pixel accepted while one is in work");

endmodule

bind color_palette_indexer cpi_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_cpi_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .color_index    (rsp_bus.color_index),
   .is_new_color   (rsp_bus.is_new_color),
   .distinct_count (rsp_bus.distinct_count),
   .table_full     (rsp_bus.table_full)
);

// ===== verif/color_palette_indexer_checker.sv =====
// ----------------------------------------------------------------------------
// color_palette_indexer_checker: result predictor and scoreboard
// Watches the pixel, result and register ports of the palette indexer, keeps
// its own copy of the color table, and compares each result with the index, flags
// and distinct count that it predicted for the oldest outstanding pixel.
// ----------------------------------------------------------------------------
module color_palette_indexer_checker #(
   parameter int TABLE_DEPTH  = 255,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   cpi_req_if                             req_mon,
   cpi_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cpi_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cpi_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             outstanding
);

   typedef struct packed {
      cpi_pkg::byte_type color_index;
      logic              is_new_color;
      cpi_pkg::byte_type distinct_count;
      logic              table_full;
   } index_result_type;

   logic [4*cpi_pkg::CHAN_W-1:0] palette_keys [TABLE_DEPTH];
   int unsigned                  stored_colors = 0;
   cpi_pkg::chan_count_type      chan_count = cpi_pkg::CC_RESET;
   index_result_type             expected_indexes [$];
   int                           mismatches = 0;

   // Looks the pixel up in the table, adding its color when it is new and
   // there is still room.
   function automatic index_result_type index_pixel(input logic sof,
                                                    input cpi_pkg::byte_type c0,
                                                    input cpi_pkg::byte_type c1,
                                                    input cpi_pkg::byte_type c2,
                                                    input cpi_pkg::byte_type c3);
      int unsigned                  used;
      logic [4*cpi_pkg::CHAN_W-1:0] key;
      cpi_pkg::byte_type            chans [4];
      index_result_type             res;
      bit                           found;
      used = chan_count;
      if (used == 0) used = 1;
      if (used > MAX_CHANNELS) used = MAX_CHANNELS;
      if (sof) stored_colors = 0;
      chans = '{c0, c1, c2, c3};
      key = '0;
      for (int c = 0; c < used; c++) key[cpi_pkg::CHAN_W*c +: cpi_pkg::CHAN_W] = chans[c];
      found = 1'b0;
      res.color_index = cpi_pkg::NOT_INDEXED;
      res.is_new_color = 1'b0;
      for (int i = 0; i < stored_colors; i++) begin
         if (!found && palette_keys[i] == key) begin
            found = 1'b1;
            res.color_index = cpi_pkg::byte_type'(i);
         end
      end
      if (!found && stored_colors < TABLE_DEPTH) begin
         palette_keys[stored_colors] = key;
         res.color_index = cpi_pkg::byte_type'(stored_colors);
         res.is_new_color = 1'b1;
         stored_colors++;
      end
      res.distinct_count = cpi_pkg::byte_type'(stored_colors);
      res.table_full = (stored_colors >= TABLE_DEPTH);
      return res;
   endfunction

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      index_result_type want;
      index_result_type pred;
      if (reset) begin
         stored_colors = 0;
         chan_count = cpi_pkg::CC_RESET;
         expected_indexes.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == cpi_pkg::REG_CHANNEL_COUNT)
            chan_count = pwdata[cpi_pkg::CC_W-1:0];
         if (req_mon.valid && req_mon.ready) begin
            pred = index_pixel(req_mon.start_of_image, req_mon.chan0,
                               req_mon.chan1, req_mon.chan2, req_mon.chan3);
            expected_indexes = {expected_indexes, pred};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_indexes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual index %0d",
                        $time, rsp_mon.color_index);
               mismatches++;
            end else begin
               want = expected_indexes.pop_front();
               compare_field("color_index", want.color_index, rsp_mon.color_index);
               compare_field("is_new_color", want.is_new_color, rsp_mon.is_new_color);
               compare_field("distinct_count", want.distinct_count, rsp_mon.distinct_count);
               compare_field("table_full", want.table_full, rsp_mon.table_full);
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= expected_indexes.size();
   end

endmodule

// ===== verif/color_palette_indexer_tb.sv =====
// ----------------------------------------------------------------------------
// color_palette_indexer_tb: testbench top of the palette indexer
// Drives pixels, register writes and result back-pressure into the block,
// while a checker beside it predicts every palette index and compares.
// ----------------------------------------------------------------------------
module color_palette_indexer_tb;

   localparam int TABLE_DEPTH  = 255;
   localparam int MAX_CHANNELS = 4;
   localparam int RESET_CYCLES = 9;
   // The limit on cycles without any transaction covers a pixel scanning a full
   // table, the longest idle bursts, the long receiver hold-off and a register
   // write, many times over.
   localparam int STALL_LIMIT  = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int PHASES       = 8;
   localparam int PHASE_PIXELS = 115;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [cpi_pkg::CSR_ADDR_W-1:0] paddr;
   logic [cpi_pkg::CSR_DATA_W-1:0] pwdata;
   logic [cpi_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // Stimulus knobs shared by the sender, the receiver and the main sequence.
   bit sender_idling   = 1'b1;
   bit receiver_idling = 1'b1;
   int hold_off_cycles = 0;
   int pixels_sent     = 0;
   int idle_cycles     = 0;
   int fail_count;
   int outstanding;

   cpi_req_if req_if ();
   cpi_rsp_if rsp_if ();

   color_palette_indexer #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   color_palette_indexer_checker #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: ends the run when no transaction moves on either channel for
   // too long, which only a hung block can cause.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result receiver. It takes results freely, stalls in random bursts while
   // idling is enabled, and holds off for a whole requested stretch when the
   // main sequence asks for one, so that the block fills up and stalls its
   // pixel input.
   initial begin : receiver
      int gap;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            gap = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (receiver_idling && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Channel value with extra weight on the two extremes.
   function automatic cpi_pkg::byte_type rand_chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return cpi_pkg::byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one pixel, after a random idle burst when idling is enabled, and
   // returns at the clock edge where the transaction is accepted. Valid is
   // left high so that back-to-back pixels never drop it.
   task automatic send_pixel(input logic sof, input cpi_pkg::byte_type c0,
                             input cpi_pkg::byte_type c1, input cpi_pkg::byte_type c2,
                             input cpi_pkg::byte_type c3);
      int gap;
      if (sender_idling && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.start_of_image <= sof;
      req_if.chan0          <= c0;
      req_if.chan1          <= c1;
      req_if.chan2          <= c2;
      req_if.chan3          <= c3;
      do @(posedge clock); while (!req_if.ready);
      pixels_sent++;
   endtask

   // Stops offering pixels and waits until every predicted result has been
   // taken. The first edge lets a transaction accepted just now reach the
   // checker's count. Every pixel yields a result, so the block is idle then.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Setup and access cycle of a write to the channel count register. The
   // unused upper data bits carry random values.
   task automatic write_channel_count(input cpi_pkg::chan_count_type setting);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {cpi_pkg::REG_CHANNEL_COUNT, 2'b00};
      pwdata  <= ($urandom() << cpi_pkg::CC_W) | cpi_pkg::CSR_DATA_W'(setting);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One image in scan order. A normal image draws its pixels from a small
   // random set of colors with some noise and the odd stray start-of-image
   // flag. A fill image brings more distinct colors than the table holds,
   // then mixes colors already stored with colors that no longer fit.
   task automatic send_image(input bit fresh, input int length, input int colors,
                             input bit fill);
      logic [4*cpi_pkg::CHAN_W-1:0] swatch [256];
      logic [4*cpi_pkg::CHAN_W-1:0] shade;
      cpi_pkg::byte_type            offset;
      logic                         sof;
      offset = rand_chan();
      // In a fill image chan0 alone keeps the first 256 colors apart, so
      // they stay distinct whatever the channel count.
      for (int s = 0; s < 256; s++)
         swatch[s] = fill ? {rand_chan(), rand_chan(), rand_chan(),
                             cpi_pkg::byte_type'(s) + offset}
                          : {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
      for (int i = 0; i < length; i++) begin
         if (fill && i < 256)
            shade = swatch[i];
         else if (fill ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 15) != 0))
            shade = swatch[$urandom_range(0, fill ? 255 : colors - 1)];
         else
            shade = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
         sof = (i == 0 && fresh) || (!fill && $urandom_range(0, 99) == 0);
         send_pixel(sof, shade[7:0], shade[15:8], shade[23:16], shade[31:24]);
      end
   endtask

   initial begin : stimulus
      int sweep [PHASES];
      int phase_end;
      bit first;
      // Channel count per random phase: both ends of the register, values
      // that act as one and as four channels, and the ones between.
      sweep = '{4, 1, 0, 7, 2, 6, 3, 5};

      req_if.valid          <= 1'b0;
      req_if.start_of_image <= 1'b0;
      req_if.chan0          <= '0;
      req_if.chan1          <= '0;
      req_if.chan2          <= '0;
      req_if.chan3          <= '0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset channel count of three: the extreme
      // colors, a difference only in the ignored fourth channel, hits, and a
      // start-of-image flag in the middle of an image.
      send_pixel(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      send_pixel(1'b0, 8'h01, 8'h02, 8'h04, 8'h08);
      send_pixel(1'b0, 8'h80, 8'h40, 8'h20, 8'h10);
      send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

      // A channel count of zero acts as one: only chan0 tells colors apart.
      drain_results();
      write_channel_count(3'd0);
      send_pixel(1'b1, 8'h07, 8'h01, 8'h01, 8'h01);
      send_pixel(1'b0, 8'h07, 8'hC8, 8'h03, 8'h03);
      send_pixel(1'b0, 8'h08, 8'h01, 8'h01, 8'h01);

      // Seven acts as four. The image goes on, so the new keys are compared
      // against entries that were stored with a single channel.
      drain_results();
      write_channel_count(3'd7);
      send_pixel(1'b0, 8'h07, 8'h01, 8'h01, 8'h01);
      send_pixel(1'b0, 8'h07, 8'h01, 8'h01, 8'h02);
      send_pixel(1'b0, 8'h07, 8'h01, 8'h01, 8'h01);

      drain_results();
      write_channel_count(3'd4);
      send_pixel(1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55);
      send_pixel(1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA);
      send_pixel(1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55);

      // A key stored with one channel matches a two-channel pixel whose
      // second channel is zero, since the stored key keeps its masking.
      drain_results();
      write_channel_count(3'd1);
      send_pixel(1'b1, 8'h05, 8'h09, 8'h09, 8'h09);
      drain_results();
      write_channel_count(3'd2);
      send_pixel(1'b0, 8'h05, 8'h00, 8'h4D, 8'h4D);
      send_pixel(1'b0, 8'h05, 8'h09, 8'h00, 8'h00);
      send_pixel(1'b0, 8'h05, 8'h09, 8'h01, 8'h01);

      // Random part in phases, one channel count per phase. Two phases open
      // with a fill image that runs the table full. The first image of a
      // phase sometimes carries on the previous image across the change.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_channel_count(cpi_pkg::chan_count_type'(sweep[phase]));
         // The last phase runs with no idling on either side.
         sender_idling   = (phase != PHASES - 1);
         receiver_idling = (phase % 3 != 2) && (phase != PHASES - 1);
         // Long receiver hold-off while pixels keep coming.
         if (phase == 3) hold_off_cycles = LONG_HOLD;
         phase_end = pixels_sent + PHASE_PIXELS;
         first = 1'b1;
         while (pixels_sent < phase_end) begin
            if (first && (phase == 1 || phase == 5))
               send_image(1'b1, TABLE_DEPTH + $urandom_range(1, 40), 1, 1'b1);
            else
               send_image(!first || $urandom_range(0, 3) != 0, $urandom_range(4, 48),
                          $urandom_range(1, 24), 1'b0);
            // Once, the sender pauses in the middle of a phase until every
            // result has come back.
            if (phase == 2 && first) drain_results();
            first = 1'b0;
         end
      end

      drain_results();
      repeat (TABLE_DEPTH + 40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== color_palette_indexer.f =====
rtl/cpi_pkg.sv
rtl/cpi_req_if.sv
rtl/cpi_rsp_if.sv
rtl/cpi_ctrl.sv
rtl/cpi_datapath.sv
rtl/color_palette_indexer.sv
rtl/cpi_checker.sv
verif/color_palette_indexer_checker.sv
verif/color_palette_indexer_tb.sv
